// File: src/hlgc_pkg.sv
// Package for the hexagonal lattice gas collision block.
// Holds the direction momentum constants, the candidate class table and the
// selection thresholds. No dependencies.
package hlgc_pkg;

   localparam int NUM_DIRS   = 6;
   localparam int NUM_STATES = 64;

   // Integer momentum of each direction bit
   localparam int DIR_DX [NUM_DIRS] = '{-100, -50, 50, 100, 50, -50};
   localparam int DIR_DY [NUM_DIRS] = '{0, 87, 87, 0, -87, -87};

   // Number of candidates in a class
   localparam logic [1:0] CNT_ONE   = 2'd1;
   localparam logic [1:0] CNT_TWO   = 2'd2;
   localparam logic [1:0] CNT_THREE = 2'd3;

   // Rounding thresholds of round(r*(n-1)/65535), half up:
   // two candidates: k=1 for r >= 32768
   // three candidates: k=1 for r >= 16384, k=2 for r >= 49152
   localparam logic [15:0] SEL2_MID  = 16'd32768;
   localparam logic [15:0] SEL3_LOW  = 16'd16384;
   localparam logic [15:0] SEL3_HIGH = 16'd49152;

   // One class: count and up to three candidates in ascending order
   typedef struct packed {
      logic [1:0] count;
      logic [5:0] cand2;
      logic [5:0] cand1;
      logic [5:0] cand0;
   } class_type;

   typedef class_type [NUM_STATES-1:0] class_table_type;

   function automatic int ones_of(input int s);
      int c;
      c = 0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         c += (s >> d) & 1;
      end
      return c;
   endfunction

   function automatic int mom_x(input int s);
      int x;
      x = 0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (((s >> d) & 1) != 0) x += DIR_DX[d];
      end
      return x;
   endfunction

   function automatic int mom_y(input int s);
      int y;
      y = 0;
      for (int d = 0; d < NUM_DIRS; d++) begin
         if (((s >> d) & 1) != 0) y += DIR_DY[d];
      end
      return y;
   endfunction

   // Evaluated at elaboration: one class per input cell
   function automatic class_table_type build_table();
      class_table_type t;
      int n;
      t = '0;
      for (int c = 0; c < NUM_STATES; c++) begin
         n = 0;
         for (int s = 0; s < NUM_STATES; s++) begin
            if (ones_of(s) == ones_of(c) && mom_x(s) == -mom_x(c) &&
                mom_y(s) == -mom_y(c)) begin
               case (n)
                  0: t[c].cand0 = 6'(s);
                  1: t[c].cand1 = 6'(s);
                  default: t[c].cand2 = 6'(s);
               endcase
               n++;
            end
         end
         t[c].count = 2'(n);
      end
      return t;
   endfunction

   localparam class_table_type CLASS_TABLE = build_table();

endpackage

// File: src/hlgc_select.sv
// Candidate lookup and random selection for one cell.
// Depends on hlgc_pkg (class table, thresholds).
module hlgc_select import hlgc_pkg::*; (
   input  logic [5:0]  cell_state,
   input  logic [15:0] random_fraction,
   output logic [5:0]  new_state
);

   class_type entry;

   // class of the incoming cell
   assign entry = CLASS_TABLE[cell_state];

   // pick candidate k by comparing the fraction against rounding thresholds
   always_comb begin
      case (entry.count)
         CNT_TWO: begin
            new_state = (random_fraction >= SEL2_MID) ? entry.cand1 : entry.cand0;
         end
         CNT_THREE: begin
            if (random_fraction >= SEL3_HIGH) new_state = entry.cand2;
            else if (random_fraction >= SEL3_LOW) new_state = entry.cand1;
            else new_state = entry.cand0;
         end
         default: begin
            new_state = entry.cand0;
         end
      endcase
   end

endmodule

// File: src/hex_lattice_gas_collision.sv
// Top level of the hexagonal lattice gas collision block.
// Depends on hlgc_pkg and hlgc_select.

// A new cell word is taken every clock cycle (busy is high only during
// reset). Each result appears on rsp_new_state with rsp_valid high for one
// cycle, after passing through the input register and then the result
// register, with the class table lookup and the threshold select in
// between. The receiver cannot stall, so results must be captured when
// rsp_valid is high.
module hex_lattice_gas_collision import hlgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_cell_state,
   input  logic [15:0] req_random_fraction,
   output logic        rsp_valid,
   output logic [5:0]  rsp_new_state
);

   logic        accept;
   logic        valid_ff, valid_in;
   logic [5:0]  cell_ff;
   logic [15:0] frac_ff;
   logic        rsp_valid_ff;
   logic [5:0]  rsp_state_ff, rsp_state_in;

   assign busy     = reset;
   assign accept   = start && !busy;
   assign valid_in = accept;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         cell_ff <= req_cell_state;
         frac_ff <= req_random_fraction;
      end
   end

   // collision lookup
   hlgc_select u_select (
      .cell_state      (cell_ff),
      .random_fraction (frac_ff),
      .new_state       (rsp_state_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= valid_ff;
      end
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_state = rsp_state_ff;

`ifndef SYNTHESIS
   // every taken word gives a result
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("missing result after accepted word");

   // no result without a taken word
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 2))
      else $error("result without accepted word");

   // collision keeps the particle count
   a_count_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_new_state) == $countones($past(req_cell_state, 2)))
      else $error("particle count changed");
`endif

endmodule

// File: tb/sv/hlgc_checker.sv
// Checker for the hexagonal lattice gas collision block: watches the cell
// channel, predicts each post-collision cell and compares it with rsp_new_state.
// Stand-alone; no package dependency.
module hlgc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [5:0]  req_cell_state,
   input  logic [15:0] req_random_fraction,
   input  logic        rsp_valid,
   input  logic [5:0]  rsp_new_state,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_FULL = 65535;

   // expected post-collision cells, oldest first
   logic [5:0] expected_cells [$];

   // sum of the direction vectors of the occupied bits
   function automatic void cell_momentum(input logic [5:0] s, output int mx, output int my);
      mx = 0;
      my = 0;
      for (int d = 0; d < 6; d++) begin
         if (s[d]) begin
            case (d)
               0: begin mx -= 100; end
               1: begin mx -= 50; my += 87; end
               2: begin mx += 50; my += 87; end
               3: begin mx += 100; end
               4: begin mx += 50; my -= 87; end
               default: begin mx -= 50; my -= 87; end
            endcase
         end
      end
   endfunction

   // scan all cells with equal particle count and reversed momentum,
   // then pick one by the rounded random fraction
   function automatic logic [5:0] collide_cell(input logic [5:0] occ, input logic [15:0] r);
      int cx, cy, sx, sy, n, k;
      logic [5:0] picks [3];
      n = 0;
      picks[0] = '0;
      picks[1] = '0;
      picks[2] = '0;
      cell_momentum(occ, cx, cy);
      for (int s = 0; s < 64; s++) begin
         if ($countones(6'(s)) == $countones(occ)) begin
            cell_momentum(6'(s), sx, sy);
            if (sx == -cx && sy == -cy) begin
               if (n < 3) picks[n] = 6'(s);
               n++;
            end
         end
      end
      // empty class cannot happen; fall back to the half-turn rotation
      if (n == 0) return {occ[2:0], occ[5:3]};
      k = (2 * int'(r) * (n - 1) + FRAC_FULL) / (2 * FRAC_FULL);
      if (k > n - 1) k = n - 1;
      if (k > 2) k = 2;
      return picks[k];
   endfunction

   task automatic note_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // results are popped before the word taken at the same edge is pushed
   always @(posedge clock) begin : watch
      logic [5:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_cells.size() == 0) begin
               note_mismatch($sformatf("result %0d with no word pending", rsp_new_state));
            end else begin
               want = expected_cells.pop_front();
               if (rsp_new_state !== want)
                  note_mismatch($sformatf("new_state got %0d expected %0d",
                                          rsp_new_state, want));
            end
         end
         if (start && !busy)
            expected_cells.push_back(collide_cell(req_cell_state, req_random_fraction));
      end
      pending = expected_cells.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for hex_lattice_gas_collision: drives directed and random cell
// words with random gaps and gives the verdict. Depends on hlgc_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [5:0]  req_cell_state;
   logic [15:0] req_random_fraction;
   logic        rsp_valid;
   logic [5:0]  rsp_new_state;
   int          fail_count;
   int          pending;

   hex_lattice_gas_collision DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cell_state      (req_cell_state),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_new_state       (rsp_new_state)
   );

   hlgc_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cell_state      (req_cell_state),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_new_state       (rsp_new_state),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop
   initial begin
      #2_000_000;
      $display("hex_lattice_gas_collision test failed");
      $finish;
   end

   // present one word; busy only changes at rising edges, so the value seen
   // at the falling edge is the one the next rising edge samples
   task automatic send_cell(input logic [5:0] c, input logic [15:0] r);
      start <= 1'b1;
      req_cell_state <= c;
      req_random_fraction <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // fractions clustered around the rounding thresholds
   function automatic logic [15:0] pick_fraction();
      logic [15:0] edges [8];
      int sel;
      edges = '{16'd0, 16'd16383, 16'd16384, 16'd32767,
                16'd32768, 16'd49151, 16'd49152, 16'd65535};
      sel = $urandom_range(0, 9);
      if (sel < 4) return 16'($urandom_range(0, 65535));
      if (sel < 7) return edges[$urandom_range(0, 7)];
      return edges[$urandom_range(1, 6)] + 16'($urandom_range(0, 4)) - 16'd2;
   endfunction

   initial begin
      int gap;
      int roll;
      start = 1'b0;
      reset = 1'b1;
      req_cell_state = '0;
      req_random_fraction = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, full, single particles, head-on pairs, symmetric
      // triples and four-particle cells around each threshold
      send_cell(6'd0, 16'd65535);
      send_cell(6'd63, 16'd0);
      send_cell(6'd1, 16'd12345);
      send_cell(6'd32, 16'd65535);
      send_cell(6'd9, 16'd0);
      send_cell(6'd9, 16'd16383);
      send_cell(6'd18, 16'd16384);
      send_cell(6'd18, 16'd49151);
      send_cell(6'd36, 16'd49152);
      send_cell(6'd36, 16'd65535);
      send_cell(6'd21, 16'd0);
      send_cell(6'd21, 16'd32767);
      send_cell(6'd42, 16'd32768);
      send_cell(6'd42, 16'd65535);
      send_cell(6'd27, 16'd16384);
      send_cell(6'd54, 16'd49152);
      send_cell(6'd45, 16'd30000);
      send_cell(6'd3, 16'd40000);
      send_cell(6'd7, 16'd65535);
      send_cell(6'd62, 16'd1);

      // random words; every third block of 40 runs back to back
      for (int i = 0; i < 500; i++) begin
         if (i == 250) begin
            // drain the pipe completely once
            start <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
            @(posedge clock);
         end else if ((i / 40) % 3 != 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) gap = 0;
            else if (roll < 90) gap = $urandom_range(1, 3);
            else gap = $urandom_range(10, 40);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_cell(6'($urandom_range(0, 63)), pick_fraction());
      end
      start <= 1'b0;

      // wait for the last results plus pipeline latency
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("hex_lattice_gas_collision test passed");
      end else begin
         $display("hex_lattice_gas_collision test failed");
      end
      $finish;
   end

endmodule
